>>> rtl/assert_macros.svh
// assertion macros shared by the allocator rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// check sampled on the rising clock, ignored while reset is asserted
`define GHA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// check sampled on the rising clock, live during reset too
`define GHA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GHA_ASSERT(lbl, clk, rstn, prop, msg)
`define GHA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

>>> rtl/gha_pkg.sv
// shared types and constants of the generational handle allocator
// no dependencies; imported by the top level
`default_nettype none

package gha_pkg;

  localparam int MAX_SLOTS_DEF    = 1024;
  localparam int VERSION_BITS_DEF = 16;
  localparam int INDEX_W          = 10;
  localparam int VER_W            = 16;
  localparam int COUNT_W          = 11;

  typedef enum logic [1:0] {
    REQ_CREATE     = 2'd0,
    REQ_DESTROY    = 2'd1,
    REQ_SET_ACTIVE = 2'd2,
    REQ_QUERY      = 2'd3
  } req_code_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef struct packed {
    req_code_t          req_type;
    logic [INDEX_W-1:0] handle_index;
    logic [VER_W-1:0]   handle_version;
    logic               active_value;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic [INDEX_W-1:0] out_index;
    logic [VER_W-1:0]   out_version;
    logic               is_valid;
    logic               is_active;
    logic [COUNT_W-1:0] live_count;
    logic [COUNT_W-1:0] active_count;
  } out_item_t;

endpackage

`default_nettype wire

>>> rtl/gha_ram.sv
// generic single write port ram with one registered read port
// no dependencies; instanced by the allocator top level
`default_nettype none

module gha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> rtl/generational_handle_allocator_unit.sv
// generational handle allocator top level: slot table, fifo free list, counters
// depends on gha_pkg, gha_ram and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

// A request is taken when start is high and busy is low. Query, destroy,
// set-active and a create that opens a fresh slot pass through the lookup
// state before the next accept; a create that reuses a queued slot also
// passes the fetch state, as it first reads the free list and then the slot.
// These steps come from the registered read port of the slot and free-list
// memories. Every request gives one result, shown for exactly one cycle with
// out_valid high; the receiver cannot stall it, so it must capture the beat in
// that cycle. No clearing pass follows reset: slots are read only once written.
module generational_handle_allocator_unit
  import gha_pkg::*;
#(
  parameter int MAX_SLOTS    = MAX_SLOTS_DEF,
  parameter int VERSION_BITS = VERSION_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  in_item_t  in_item,
  output logic      busy,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam int IDX_W  = $clog2(MAX_SLOTS);
  localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
  localparam int SW     = VERSION_BITS + 2;
  localparam int LIVE_B = VERSION_BITS + 1;
  localparam int ACT_B  = VERSION_BITS;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_FETCH
  } state_t;

  state_t            state_r, state_nxt;
  in_item_t          req_r, req_nxt;
  logic [IDX_W-1:0]  n_r, n_nxt;
  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [IDX_W-1:0]  tail_r, tail_nxt;
  logic [CNT_W-1:0]  free_cnt_r, free_cnt_nxt;
  logic [CNT_W-1:0]  hw_r, hw_nxt;
  logic [CNT_W-1:0]  live_r, live_nxt;
  logic [CNT_W-1:0]  act_r, act_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r, out_nxt;

  logic              slot_we;
  logic [IDX_W-1:0]  slot_waddr, slot_raddr;
  logic [SW-1:0]     slot_wdata, slot_rdata;
  logic              fq_we;
  logic [IDX_W-1:0]  fq_rdata, fq_idx;

  logic [VERSION_BITS-1:0] cur_ver, new_ver;
  logic              idx_used, ver_hit, handle_ok, cur_act;

  gha_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_SLOTS)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (slot_we),
    .wr_addr (slot_waddr),
    .wr_data (slot_wdata),
    .rd_addr (slot_raddr),
    .rd_data (slot_rdata)
  );

  gha_ram #(
    .WIDTH (IDX_W),
    .DEPTH (MAX_SLOTS)
  ) u_free_ram (
    .clk     (clk),
    .wr_en   (fq_we),
    .wr_addr (tail_r),
    .wr_data (IDX_W'(req_r.handle_index)),
    .rd_addr (head_r),
    .rd_data (fq_rdata)
  );

  always_comb begin
    cur_ver   = slot_rdata[VERSION_BITS-1:0];
    cur_act   = slot_rdata[ACT_B];
    new_ver   = cur_ver + 1'b1;
    idx_used  = 32'(req_r.handle_index) < 32'(hw_r);
    ver_hit   = cur_ver == VERSION_BITS'(req_r.handle_version);
    handle_ok = idx_used && slot_rdata[LIVE_B] && ver_hit;
    fq_idx    = (32'(fq_rdata) >= MAX_SLOTS) ? '0 : fq_rdata;

    state_nxt     = state_r;
    req_nxt       = req_r;
    n_nxt         = n_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    free_cnt_nxt  = free_cnt_r;
    hw_nxt        = hw_r;
    live_nxt      = live_r;
    act_nxt       = act_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    slot_we       = 1'b0;
    slot_waddr    = IDX_W'(req_r.handle_index);
    slot_wdata    = {1'b0, 1'b0, cur_ver};
    slot_raddr    = IDX_W'(in_item.handle_index);
    fq_we         = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt   = in_item;
          state_nxt = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (req_r.req_type == REQ_CREATE) begin
          if (free_cnt_r != '0) begin
            n_nxt        = fq_idx;
            slot_raddr   = fq_idx;
            head_nxt     = (head_r == IDX_W'(MAX_SLOTS - 1)) ? '0 : head_r + 1'b1;
            free_cnt_nxt = free_cnt_r - 1'b1;
            state_nxt    = S_FETCH;
          end else begin
            state_nxt     = S_IDLE;
            out_valid_nxt = 1'b1;
            out_nxt       = '0;
            if (hw_r < CNT_W'(MAX_SLOTS)) begin
              slot_we    = 1'b1;
              slot_waddr = IDX_W'(hw_r);
              slot_wdata = {1'b1, req_r.active_value, {VERSION_BITS{1'b0}}};
              hw_nxt     = hw_r + 1'b1;
              live_nxt   = live_r + 1'b1;
              act_nxt    = act_r + CNT_W'(req_r.active_value);
              out_nxt.status    = ST_OK;
              out_nxt.out_index = INDEX_W'(hw_r);
              out_nxt.is_valid  = 1'b1;
              out_nxt.is_active = req_r.active_value;
            end else begin
              out_nxt.status = ST_FULL;
            end
          end
        end else begin
          state_nxt           = S_IDLE;
          out_valid_nxt       = 1'b1;
          out_nxt             = '0;
          out_nxt.status      = handle_ok ? ST_OK : ST_INVALID;
          out_nxt.out_index   = req_r.handle_index;
          out_nxt.out_version = idx_used ? VER_W'(cur_ver) : '0;
          if (handle_ok) begin
            case (req_r.req_type)
              REQ_DESTROY: begin
                slot_we    = 1'b1;
                slot_wdata = {1'b0, 1'b0, new_ver};
                if (cur_act && act_r != '0) begin
                  act_nxt = act_r - 1'b1;
                end
                if (live_r != '0) begin
                  live_nxt = live_r - 1'b1;
                end
                if (free_cnt_r < CNT_W'(MAX_SLOTS)) begin
                  fq_we        = 1'b1;
                  tail_nxt     = (tail_r == IDX_W'(MAX_SLOTS - 1)) ? '0 : tail_r + 1'b1;
                  free_cnt_nxt = free_cnt_r + 1'b1;
                end
                out_nxt.out_version = VER_W'(new_ver);
              end
              REQ_SET_ACTIVE: begin
                slot_we    = 1'b1;
                slot_wdata = {1'b1, req_r.active_value, cur_ver};
                if (cur_act && !req_r.active_value && act_r != '0) begin
                  act_nxt = act_r - 1'b1;
                end else if (!cur_act && req_r.active_value) begin
                  act_nxt = act_r + 1'b1;
                end
                out_nxt.is_valid  = 1'b1;
                out_nxt.is_active = req_r.active_value;
              end
              REQ_QUERY: begin
                out_nxt.is_valid  = 1'b1;
                out_nxt.is_active = cur_act;
              end
              default: begin
                out_nxt.is_valid = 1'b0;
              end
            endcase
          end
        end
      end
      S_FETCH: begin
        state_nxt           = S_IDLE;
        out_valid_nxt       = 1'b1;
        slot_we             = 1'b1;
        slot_waddr          = n_r;
        slot_wdata          = {1'b1, req_r.active_value, cur_ver};
        live_nxt            = live_r + 1'b1;
        act_nxt             = act_r + CNT_W'(req_r.active_value);
        out_nxt             = '0;
        out_nxt.status      = ST_OK;
        out_nxt.out_index   = INDEX_W'(n_r);
        out_nxt.out_version = VER_W'(cur_ver);
        out_nxt.is_valid    = 1'b1;
        out_nxt.is_active   = req_r.active_value;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_nxt.live_count   = COUNT_W'(live_nxt);
    out_nxt.active_count = COUNT_W'(act_nxt);
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    n_r   <= n_nxt;
    out_r <= out_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      free_cnt_r  <= '0;
      hw_r        <= '0;
      live_r      <= '0;
      act_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      free_cnt_r  <= free_cnt_nxt;
      hw_r        <= hw_nxt;
      live_r      <= live_nxt;
      act_r       <= act_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  `GHA_ASSERT(a_beat_when_idle, clk, rst_n, out_valid |-> !busy, "result beat while busy")
  `GHA_ASSERT(a_accept_busy, clk, rst_n, start && !busy |=> busy, "accept did not raise busy")
  `GHA_ASSERT(a_slot_balance, clk, rst_n,
    state_r != S_FETCH |-> live_r + free_cnt_r == hw_r, "live plus free differs from used")
  `GHA_ASSERT(a_active_le_live, clk, rst_n, act_r <= live_r, "active count above live count")
  `GHA_ASSERT(a_full_only_at_top, clk, rst_n,
    out_valid && out_item.status == ST_FULL |-> hw_r == CNT_W'(MAX_SLOTS), "full with slots left")

endmodule

`default_nettype wire

>>> tb/gha_tb_pkg.sv
// tracking model of the handle allocator: slot table, fifo free list, counters
// keeps the replies due from the block and compares each reply beat against them
// depends on gha_pkg
package gha_tb_pkg;
  import gha_pkg::*;

  class handle_table_tracker;
    bit [VER_W-1:0]   slot_ver [MAX_SLOTS_DEF];
    bit               slot_live [MAX_SLOTS_DEF];
    bit               slot_act [MAX_SLOTS_DEF];
    bit [INDEX_W-1:0] free_fifo [MAX_SLOTS_DEF];
    bit [INDEX_W-1:0] free_rd;
    bit [INDEX_W-1:0] free_wr;
    bit [COUNT_W-1:0] free_cnt;
    bit [COUNT_W-1:0] next_fresh;
    bit [COUNT_W-1:0] live_cnt;
    bit [COUNT_W-1:0] active_cnt;
    out_item_t        replies_due [$];
    int               mismatches;

    function out_item_t predict_reply(in_item_t rq);
      out_item_t        rp;
      bit [INDEX_W-1:0] idx;
      bit               in_use;
      bit               ok;
      rp = '0;
      idx = rq.handle_index;
      in_use = ({1'b0, idx} < next_fresh);
      if (rq.req_type == REQ_CREATE) begin
        ok = 1'b1;
        if (free_cnt != 0) begin
          idx = free_fifo[free_rd];
          free_rd++;
          free_cnt--;
        end else if (next_fresh < MAX_SLOTS_DEF) begin
          idx = next_fresh[INDEX_W-1:0];
          slot_ver[idx] = '0;
          next_fresh++;
        end else begin
          ok = 1'b0;
        end
        if (ok) begin
          slot_live[idx] = 1'b1;
          slot_act[idx] = rq.active_value;
          live_cnt++;
          active_cnt += rq.active_value;
          rp.status = ST_OK;
          rp.out_index = idx;
          rp.out_version = slot_ver[idx];
          rp.is_valid = 1'b1;
          rp.is_active = rq.active_value;
        end else begin
          rp.status = ST_FULL;
        end
      end else begin
        ok = in_use && slot_live[idx] && (slot_ver[idx] == rq.handle_version);
        rp.out_index = idx;
        if (!ok) begin
          rp.status = ST_INVALID;
        end else begin
          rp.status = ST_OK;
          case (rq.req_type)
            REQ_DESTROY: begin
              if (slot_act[idx]) active_cnt--;
              live_cnt--;
              slot_live[idx] = 1'b0;
              slot_act[idx] = 1'b0;
              slot_ver[idx]++;
              free_fifo[free_wr] = idx;
              free_wr++;
              free_cnt++;
            end
            REQ_SET_ACTIVE: begin
              if (slot_act[idx] && !rq.active_value) active_cnt--;
              else if (!slot_act[idx] && rq.active_value) active_cnt++;
              slot_act[idx] = rq.active_value;
              rp.is_valid = 1'b1;
              rp.is_active = rq.active_value;
            end
            default: begin
              rp.is_valid = 1'b1;
              rp.is_active = slot_act[idx];
            end
          endcase
        end
        rp.out_version = in_use ? slot_ver[idx] : '0;
      end
      rp.live_count = live_cnt;
      rp.active_count = active_cnt;
      return rp;
    endfunction

    function void take_request(in_item_t rq);
      replies_due = {replies_due, predict_reply(rq)};
    endfunction

    function void check_reply(out_item_t got);
      out_item_t want;
      if (replies_due.size() == 0) begin
        $error("reply beat with none due: %h", got);
        mismatches++;
        return;
      end
      want = replies_due.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        mismatches++;
      end
      if (got.out_index !== want.out_index) begin
        $error("out_index: expected %0d, got %0d", want.out_index, got.out_index);
        mismatches++;
      end
      if (got.out_version !== want.out_version) begin
        $error("out_version: expected %0d, got %0d", want.out_version, got.out_version);
        mismatches++;
      end
      if (got.is_valid !== want.is_valid) begin
        $error("is_valid: expected %0d, got %0d", want.is_valid, got.is_valid);
        mismatches++;
      end
      if (got.is_active !== want.is_active) begin
        $error("is_active: expected %0d, got %0d", want.is_active, got.is_active);
        mismatches++;
      end
      if (got.live_count !== want.live_count) begin
        $error("live_count: expected %0d, got %0d", want.live_count, got.live_count);
        mismatches++;
      end
      if (got.active_count !== want.active_count) begin
        $error("active_count: expected %0d, got %0d", want.active_count, got.active_count);
        mismatches++;
      end
    endfunction

    function int due_count();
      return replies_due.size();
    endfunction

    function bit pick_live(output bit [INDEX_W-1:0] idx, output bit [VER_W-1:0] ver);
      idx = '0;
      ver = '0;
      if (live_cnt == 0) return 1'b0;
      repeat (64) begin
        idx = INDEX_W'($urandom_range(0, next_fresh - 1));
        if (slot_live[idx]) begin
          ver = slot_ver[idx];
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction
  endclass

endpackage

>>> tb/generational_handle_allocator_unit_tb.sv
// testbench top of the generational handle allocator: directed, slot-reuse,
// table-fill and random request beats with random start gaps, replies checked
// depends on gha_pkg, gha_tb_pkg and the allocator rtl
module generational_handle_allocator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gha_pkg::*;
  import gha_tb_pkg::*;

  localparam int QUIET_LIMIT = 400;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  in_item_t  in_item = '0;
  logic      busy;
  logic      out_valid;
  out_item_t out_item;

  handle_table_tracker tracker = new();
  int                  quiet_cycles = 0;

  always #2 clk = ~clk;

  generational_handle_allocator_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_item   (in_item),
    .busy      (busy),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) tracker.check_reply(out_item);
      if ((start && !busy) || out_valid) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  function automatic in_item_t make_req(req_code_t op, bit [INDEX_W-1:0] idx,
                                        bit [VER_W-1:0] ver, bit act);
    in_item_t rq;
    rq.req_type = op;
    rq.handle_index = idx;
    rq.handle_version = ver;
    rq.active_value = act;
    return rq;
  endfunction

  function automatic in_item_t rand_create();
    return make_req(REQ_CREATE, INDEX_W'($urandom), VER_W'($urandom), 1'($urandom));
  endfunction

  function automatic in_item_t noise_req();
    bit [INDEX_W-1:0] idx;
    bit [VER_W-1:0]   ver;
    idx = INDEX_W'($urandom);
    ver = VER_W'($urandom);
    if (idx < tracker.next_fresh && $urandom_range(0, 1))
      ver = VER_W'(tracker.slot_ver[idx] + $urandom_range(0, 1));
    return make_req(req_code_t'($urandom_range(0, 3)), idx, ver, 1'($urandom));
  endfunction

  task automatic send_request(input in_item_t rq);
    start <= 1'b1;
    in_item <= rq;
    @(posedge clk);
    while (busy) @(posedge clk);
    tracker.take_request(rq);
  endtask

  task automatic maybe_pause(input int odds);
    if (odds > 0 && $urandom_range(1, odds) == 1) begin
      start <= 1'b0;
      in_item <= noise_req();
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic drain_replies();
    start <= 1'b0;
    do @(posedge clk); while (tracker.due_count() != 0);
  endtask

  task automatic random_beat(input int create_w, input int destroy_w, input int odds);
    int               roll;
    bit [INDEX_W-1:0] idx;
    bit [VER_W-1:0]   ver;
    in_item_t         rq;
    roll = $urandom_range(0, 99);
    if (roll < create_w) begin
      rq = rand_create();
    end else if (roll < 85 && tracker.pick_live(idx, ver)) begin
      if (roll < create_w + destroy_w) rq = make_req(REQ_DESTROY, idx, ver, 1'($urandom));
      else if ($urandom_range(0, 1)) rq = make_req(REQ_SET_ACTIVE, idx, ver, 1'($urandom));
      else rq = make_req(REQ_QUERY, idx, ver, 1'($urandom));
    end else begin
      rq = noise_req();
    end
    send_request(rq);
    maybe_pause(odds);
  endtask

  initial begin
    bit [INDEX_W-1:0] slot;
    bit [VER_W-1:0]   ver;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table, then a few slots through their life cycle
    send_request(make_req(REQ_QUERY, 10'd0, 16'd0, 1'b0));
    send_request(make_req(REQ_DESTROY, 10'd1023, 16'hFFFF, 1'b1));
    send_request(make_req(REQ_SET_ACTIVE, 10'd5, 16'd0, 1'b1));
    send_request(make_req(REQ_CREATE, 10'd1023, 16'hFFFF, 1'b1));
    send_request(make_req(REQ_CREATE, 10'd0, 16'd0, 1'b0));
    maybe_pause(1);
    send_request(make_req(REQ_CREATE, 10'd0, 16'd0, 1'b1));
    send_request(make_req(REQ_QUERY, 10'd0, 16'd0, 1'b0));
    send_request(make_req(REQ_QUERY, 10'd1, 16'd0, 1'b1));
    send_request(make_req(REQ_QUERY, 10'd0, 16'hFFFF, 1'b0));
    send_request(make_req(REQ_SET_ACTIVE, 10'd1, 16'd0, 1'b1));
    send_request(make_req(REQ_SET_ACTIVE, 10'd0, 16'd0, 1'b0));
    send_request(make_req(REQ_DESTROY, 10'd2, 16'd0, 1'b0));
    maybe_pause(1);
    send_request(make_req(REQ_DESTROY, 10'd2, 16'd0, 1'b0));
    send_request(make_req(REQ_QUERY, 10'd2, 16'd1, 1'b0));
    send_request(make_req(REQ_SET_ACTIVE, 10'd2, 16'd1, 1'b1));
    send_request(make_req(REQ_CREATE, 10'd0, 16'd0, 1'b1));
    send_request(make_req(REQ_QUERY, 10'd2, 16'd1, 1'b0));
    send_request(make_req(REQ_QUERY, 10'd1023, 16'd0, 1'b0));
    send_request(make_req(REQ_DESTROY, 10'd0, 16'd0, 1'b1));
    send_request(make_req(REQ_DESTROY, 10'd1, 16'd0, 1'b1));
    send_request(make_req(REQ_CREATE, 10'd0, 16'd0, 1'b0));
    drain_replies();

    // free list emptied, then one slot cycled through repeated reuse
    while (tracker.free_cnt != 0) begin
      send_request(rand_create());
      maybe_pause(4);
    end
    void'(tracker.pick_live(slot, ver));
    repeat (40) begin
      send_request(make_req(REQ_DESTROY, slot, tracker.slot_ver[slot], 1'($urandom)));
      send_request(rand_create());
      maybe_pause(20);
    end
    send_request(make_req(REQ_QUERY, slot, tracker.slot_ver[slot], 1'b0));

    // fill every slot, then ask for more
    while (!(tracker.next_fresh == MAX_SLOTS_DEF && tracker.free_cnt == 0)) begin
      send_request(rand_create());
      maybe_pause(8);
    end
    repeat (3) send_request(rand_create());
    send_request(make_req(REQ_QUERY, 10'd1023, tracker.slot_ver[1023], 1'b0));
    drain_replies();

    repeat (230) random_beat(20, 45, 4);
    drain_replies();
    repeat (230) random_beat(30, 25, 4);
    repeat (230) random_beat(45, 15, 0);

    start <= 1'b0;
    do @(posedge clk); while (tracker.due_count() != 0);
    repeat (10) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.due_count() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
